// ===== rtl/s256_pkg.sv =====
// SHA-256 stream hasher package: round constants, initial hash values and
// the round and schedule helper functions. No dependencies.
`timescale 1ns / 1ps
package s256_pkg;
	localparam int WordW = 32;
	localparam int CountW = 61;
	localparam int BlkDepth = 16;
	localparam int CvDepth = 8;

	typedef logic [WordW-1:0] word_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		begin
			case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t h;
		begin
			case (i)
				3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
				3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
				3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
				3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
			endcase
			return h;
		end
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
endpackage

// ===== rtl/s256_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module s256_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/s256_round.sv =====
// One SHA-256 round on the working variables plus the rolling message
// schedule window. Uses s256_pkg.
`timescale 1ns / 1ps
module s256_round (
	input  logic             clk,
	input  logic             load,
	input  s256_pkg::word_t  init_vars [8],
	input  logic             step,
	input  logic [5:0]       rnd,
	input  s256_pkg::word_t  w_in,
	output s256_pkg::word_t  vars [8]
);
	import s256_pkg::*;

	word_t win_q [16];
	word_t vars_q [8];
	word_t wt, w_new, t1, t2;

	assign w_new = sig1(win_q[14]) + win_q[9] + sig0(win_q[1]) + win_q[0];
	assign wt = (rnd < 6'd16) ? w_in : w_new;
	assign t1 = vars_q[7] + bsig1(vars_q[4])
		+ ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) + round_k(rnd) + wt;
	assign t2 = bsig0(vars_q[0])
		+ ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
	assign vars = vars_q;

	always_ff @(posedge clk) begin
		if (load) begin
			vars_q <= init_vars;
		end else if (step) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= wt;
		end
	end
endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: byte packing, padding and control.
// Uses s256_pkg, s256_ram (block words), s256_round.
//
// Slave channel s_axis: one message byte per beat; tuser = {message_end,
// byte_valid}. A beat with both low is ignored. message_end closes the
// message after the beat's byte, if any, so an empty message is hashed.
// Master channel m_axis: eight digest words per message, word 0 first;
// tuser = word_index, tlast marks word 7.
// Sequence: a byte beat that does not fill a block does a memory
// read-modify-write of the block word. Filling the 64th byte does the
// read-modify-write, a fetch of word 0 and a load of the working
// variables, 64 rounds, one per cycle, and a fold into the chaining
// value. A message end adds padding writes per padded block, one or two
// compressions, 8 digest beats and a restart. The input is not ready
// while a block is compressed or digest beats are pending. Digest words
// leave from an output register; a stalled receiver holds the current
// beat and stops the readout.
// Reset returns the chaining value to the initial hash and clears the
// byte count; the block memory needs no clearing.
`timescale 1ns / 1ps
module sha256_stream_hasher #(
	parameter int CountWidth = s256_pkg::CountW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] message_byte
	input  logic [1:0]  s_axis_tuser,  // [0] byte_valid, [1] message_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);
	import s256_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_RMW = 4'd1, ST_PAD = 4'd2,
		ST_LOAD = 4'd3, ST_ROUND = 4'd4, ST_FOLD = 4'd5, ST_OUT = 4'd6,
		ST_LEN = 4'd7, ST_ZERO = 4'd8, ST_PRIME = 4'd9, ST_REREAD = 4'd10;

	logic [3:0] state_q;
	logic [CountWidth-1:0] count_q;
	logic [CountWidth+2:0] bits;
	logic end_q, second_q, pad_q;
	logic [1:0] pos_q;
	logic [7:0] byte_q;
	logic [3:0] idx_q;
	logic [6:0] rnd_q;
	word_t cv_q [8];
	word_t init_v [8];
	word_t vars [8];
	logic [3:0] bw_waddr, bw_raddr;
	word_t bw_wdata, bw_rdata;
	logic bw_we, load, step;
	logic [3:0] oidx_q;
	logic [5:0] fill;
	logic s_acc;

	s256_ram #(.Width(WordW), .Depth(BlkDepth)) u_blk (
		.clk(clk), .we(bw_we), .waddr(bw_waddr), .wdata(bw_wdata),
		.raddr(bw_raddr), .rdata(bw_rdata)
	);

	assign init_v = cv_q;
	assign load = (state_q == ST_LOAD);
	assign step = (state_q == ST_ROUND);

	s256_round u_rnd (
		.clk(clk), .load(load), .init_vars(init_v), .step(step),
		.rnd(rnd_q[5:0]), .w_in(bw_rdata), .vars(vars)
	);

	assign fill = count_q[5:0];
	assign bits = {count_q, 3'b000};
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		bw_we = 1'b0;
		bw_waddr = idx_q;
		bw_wdata = bw_rdata;
		bw_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: bw_raddr = fill[5:2];
			ST_REREAD: bw_raddr = fill[5:2];
			ST_RMW: begin
				bw_we = 1'b1;
				bw_waddr = fill[5:2];
				case (fill[1:0])
					2'd0: bw_wdata = {byte_q, 24'h0};
					2'd1: bw_wdata = {bw_rdata[31:24], byte_q, 16'h0};
					2'd2: bw_wdata = {bw_rdata[31:16], byte_q, 8'h0};
					default: bw_wdata = {bw_rdata[31:8], byte_q};
				endcase
			end
			ST_PAD: begin
				bw_we = 1'b1;
				bw_waddr = fill[5:2];
				case (fill[1:0])
					2'd0: bw_wdata = 32'h8000_0000;
					2'd1: bw_wdata = {bw_rdata[31:24], 24'h80_0000};
					2'd2: bw_wdata = {bw_rdata[31:16], 16'h8000};
					default: bw_wdata = {bw_rdata[31:8], 8'h80};
				endcase
			end
			ST_ZERO: begin
				bw_we = 1'b1;
				bw_wdata = '0;
			end
			ST_LEN: begin
				bw_we = 1'b1;
				bw_waddr = {3'b111, pos_q[0]};
				bw_wdata = pos_q[0] ? bits[31:0] : 32'(bits[CountWidth+2:32]);
			end
			ST_PRIME: bw_raddr = '0;
			ST_LOAD: bw_raddr = '0;
			ST_ROUND: bw_raddr = 4'(rnd_q + 7'd1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			end_q <= 1'b0;
			second_q <= 1'b0;
			pad_q <= 1'b0;
			pos_q <= '0;
			idx_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= init_hash(3'(i));
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_acc) begin
					byte_q <= s_axis_tdata;
					end_q <= s_axis_tuser[1];
					if (s_axis_tuser[0]) state_q <= ST_RMW;
					else if (s_axis_tuser[1]) state_q <= ST_PAD;
				end
				ST_RMW: begin
					count_q <= count_q + 1'b1;
					if (fill == 6'd63) begin
						state_q <= ST_PRIME;
					end else if (end_q) begin
						state_q <= ST_REREAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REREAD: state_q <= ST_PAD;
				ST_PAD: begin
					// 0x80 written; zero the remaining words of the block
					idx_q <= fill[5:2] + 4'd1;
					second_q <= 1'b0;
					pad_q <= 1'b1;
					if (fill[5:2] == 4'd15) state_q <= ST_PRIME;
					else state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd15) begin
						if (end_q && (second_q || fill < 6'd56)) begin
							pos_q <= '0;
							state_q <= ST_LEN;
						end else begin
							state_q <= ST_PRIME;
						end
					end
				end
				ST_LEN: begin
					pos_q <= pos_q + 2'd1;
					if (pos_q[0]) state_q <= ST_PRIME;
				end
				ST_PRIME: state_q <= ST_LOAD;
				ST_LOAD: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + vars[i];
					if (!end_q) begin
						state_q <= ST_IDLE;
					end else if (!pad_q) begin
						// message ended on a full block: pad a fresh one
						state_q <= ST_PAD;
					end else if (!second_q && fill >= 6'd56) begin
						second_q <= 1'b1;
						idx_q <= '0;
						state_q <= ST_ZERO;
					end else begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (m_axis_tready || !m_axis_tvalid) begin
					if (oidx_q == 4'd8) begin
						oidx_q <= '0;
						end_q <= 1'b0;
						pad_q <= 1'b0;
						count_q <= '0;
						for (int i = 0; i < 8; i++) cv_q[i] <= init_hash(3'(i));
						state_q <= ST_IDLE;
					end else begin
						oidx_q <= oidx_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loads a word whenever the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (m_axis_tready || !m_axis_tvalid) begin
			m_axis_tvalid <= (state_q == ST_OUT) && (oidx_q != 4'd8);
			m_axis_tdata <= cv_q[oidx_q[2:0]];
			m_axis_tuser <= oidx_q[2:0];
			m_axis_tlast <= (oidx_q == 4'd7);
		end
	end

	a_no_in_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input ready while busy");
	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("digest beat outside readout");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
		else $error("tlast not on word 7");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && oidx_q == 4'd8 && (m_axis_tready || !m_axis_tvalid))
		|=> count_q == '0)
		else $error("byte count not cleared");
endmodule

// ===== verif/tb.sv =====
// Testbench for sha256_stream_hasher: byte beats in, digest words out, with a
// built-in SHA-256 predictor, random idling on both sides and one long output stall.
// Depends on rtl/s256_pkg.sv and rtl/sha256_stream_hasher.sv.
`timescale 1ns / 1ps
module tb;
	localparam int WatchLimit = 5000;
	localparam int ItemTarget = 360;
	localparam int BoundLen [4] = '{55, 56, 63, 64};
	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [255:0] InitHash =
		256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;
	localparam logic [255:0] EmptyDigest =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] AbcDigest =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	typedef struct {
		logic [7:0]   data;
		logic         has_byte;
		logic         msg_end;
		logic         fixed;
		logic [255:0] digest;
	} byte_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	digest_beat_t digest_q[$];
	logic [7:0]   blk_bytes[64];
	logic [31:0]  hash_state[8];
	logic [60:0]  msg_count;
	logic         fixed_valid = 1'b0;
	logic [255:0] fixed_digest;
	int           errors = 0;
	int           items_sent = 0;
	int           idle_cycles = 0;
	int           hold_cycles = 0;
	bit           hold_done = 0;
	bit           no_idle = 0;

	sha256_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		begin
			for (int i = 0; i < 16; i++)
				w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			{a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
				hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
			for (int i = 0; i < 64; i++) begin
				t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ RoundK[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				{h, g, f, e, d, c, b, a} = {g, f, e, d + t1, c, b, a, t1 + t2};
			end
			hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
			hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
		end
	endtask

	task automatic hash_reset();
		begin
			for (int i = 0; i < 8; i++)
				hash_state[i] = InitHash[255 - 32*i -: 32];
			msg_count = '0;
		end
	endtask

	task automatic hash_beat(input logic [7:0] data, input logic has_byte, input logic msg_end);
		int fill;
		logic [63:0] bit_len;
		logic [255:0] dig;
		digest_beat_t beat;
		begin
			if (has_byte) begin
				blk_bytes[msg_count[5:0]] = data;
				msg_count = msg_count + 1'b1;
				if (msg_count[5:0] == 6'd0)
					compress_block();
			end
			if (msg_end) begin
				fill = msg_count[5:0];
				bit_len = {msg_count, 3'b000};
				blk_bytes[fill] = 8'h80;
				for (int i = fill + 1; i < 64; i++)
					blk_bytes[i] = 8'h00;
				if (fill >= 56) begin
					compress_block();
					for (int i = 0; i < 64; i++)
						blk_bytes[i] = 8'h00;
				end
				for (int i = 0; i < 8; i++)
					blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
				compress_block();
				for (int i = 0; i < 8; i++)
					dig[255 - 32*i -: 32] = hash_state[i];
				if (fixed_valid)
					dig = fixed_digest;
				fixed_valid = 1'b0;
				for (int i = 0; i < 8; i++) begin
					beat.word = dig[255 - 32*i -: 32];
					beat.idx = 3'(i);
					beat.last = (i == 7);
					digest_q.push_back(beat);
				end
				hash_reset();
			end
		end
	endtask

	function automatic int gap_len();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (no_idle || r < 55)
				return 0;
			if (r < 92)
				return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	task automatic send_beat(input byte_row_t row);
		int gap;
		begin
			gap = gap_len();
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			fixed_valid = row.fixed;
			fixed_digest = row.digest;
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= row.data;
			s_axis_tuser <= {row.msg_end, row.has_byte};
			do @(posedge clk); while (!s_axis_tready);
			if (row.has_byte || row.msg_end)
				items_sent++;
		end
	endtask

	task automatic send_message(input int len);
		byte_row_t row;
		bit sep_end;
		begin
			sep_end = $urandom_range(0, 1);
			no_idle = ($urandom_range(0, 9) < 3);
			row.fixed = 1'b0;
			row.digest = '0;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					row.data = 8'($urandom);
					row.has_byte = 1'b0;
					row.msg_end = 1'b0;
					send_beat(row);
				end
				row.data = 8'($urandom);
				row.has_byte = 1'b1;
				row.msg_end = (i == len - 1) && !sep_end;
				send_beat(row);
			end
			if (sep_end || len == 0) begin
				row.data = 8'($urandom);
				row.has_byte = 1'b0;
				row.msg_end = 1'b1;
				send_beat(row);
			end
		end
	endtask

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			hash_beat(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
	end

	always @(posedge clk) begin
		digest_beat_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("digest beat with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = digest_q.pop_front();
				if (m_axis_tdata !== want.word) begin
					$error("digest_word: expected %h, got %h", want.word, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.idx) begin
					$error("word_index: expected %0d, got %0d", want.idx, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_word: expected %0b, got %0b", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int r;
		if (!hold_done && items_sent >= 40) begin
			hold_done = 1;
			hold_cycles = 600;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				hold_cycles = $urandom_range(10, 40);
			m_axis_tready <= (r >= 25);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		byte_row_t rows[$];
		int r, len;
		hash_reset();
		rows = '{
			'{8'h5a, 1'b0, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
			'{8'h61, 1'b1, 1'b0, 1'b0, '0},
			'{8'h62, 1'b1, 1'b0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, 1'b0, '0},
			'{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
			'{8'hff, 1'b1, 1'b0, 1'b0, '0},
			'{8'h00, 1'b1, 1'b0, 1'b0, '0},
			'{8'h80, 1'b1, 1'b0, 1'b0, '0},
			'{8'h7f, 1'b1, 1'b0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b1, 1'b0, '0},
			'{8'h00, 1'b1, 1'b1, 1'b0, '0},
			'{8'hff, 1'b1, 1'b1, 1'b0, '0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (rows[i])
			send_beat(rows[i]);
		// padding boundaries: one and two final blocks, exact block fill
		foreach (BoundLen[i])
			send_message(BoundLen[i]);
		while (items_sent < ItemTarget) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 16)
				len = $urandom_range(54, 66);
			else
				len = $urandom_range(1, 12);
			send_message(len);
		end
		s_axis_tvalid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
